// ----- design/lrqe_pkg.sv -----
// Package of the light range quad emitter: controller/datapath command and
// status types, sequencing constants and the corner sign tables.
// Depends on nothing.
`default_nettype none
package lrqe_pkg;

  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] CALC_LAST = 7'd14;
  localparam logic [CNT_W-1:0] SQRT_LAST = 7'd63;
  localparam logic [CNT_W-1:0] DIV_LAST  = 7'd81;
  localparam int DIV_W   = 82;
  localparam int RANGE_W = 41;
  localparam int SLOT_OUT_W = 13;
  localparam logic [2:0] LAST_CORNER = 3'd5;

  typedef struct packed {
    logic       load;
    logic       calc;
    logic [3:0] step;
    logic       sqrt_step;
    logic       prep;
    logic       div_step;
    logic       latch_range;
    logic       load_vtx;
    logic       finish;
  } lrqe_cmd_t;

  typedef struct packed {
    logic calc_skip;
    logic a_zero;
    logic prep_skip;
    logic range_zero;
    logic out_taken;
    logic out_last;
  } lrqe_status_t;

  // True where the corner offset is -1 along x or y.
  function automatic logic corner_x_neg(input logic [2:0] k);
    logic r;
    case (k)
      3'd0, 3'd2, 3'd3: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic corner_y_neg(input logic [2:0] k);
    logic r;
    case (k)
      3'd0, 3'd1, 3'd4: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/lrqe_if.sv -----
// Channel interfaces for light records and quad vertices.
// Self-contained; valid/ready handshake with source and sink modports.
`default_nettype none
interface lrqe_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] light_x;
  logic signed [31:0] light_y;
  logic signed [31:0] color_red;
  logic signed [31:0] color_green;
  logic signed [31:0] color_blue;
  logic signed [31:0] atten_constant;
  logic signed [31:0] atten_linear;
  logic signed [31:0] atten_quadratic;
  logic signed [31:0] atten_bias;
  logic               batch_end;
  modport source (output valid, light_x, light_y, color_red, color_green, color_blue,
                  atten_constant, atten_linear, atten_quadratic, atten_bias, batch_end,
                  input ready);
  modport sink (input valid, light_x, light_y, color_red, color_green, color_blue,
                atten_constant, atten_linear, atten_quadratic, atten_bias, batch_end,
                output ready);
endinterface

interface lrqe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic [12:0]        vertex_slot;
  logic               last_vertex;
  logic               buffer_full;
  modport source (output valid, vertex_x, vertex_y, vertex_slot, last_vertex, buffer_full,
                  input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_slot, last_vertex, buffer_full,
                output ready);
endinterface
`default_nettype wire

// ----- design/light_range_quad_emitter.sv -----
// Top level of the light range quad emitter: sequencer plus datapath.
// Uses lrqe_pkg, lrqe_if.sv, lrqe_ctrl and lrqe_datapath.
//
// One light record is taken per transaction on in_ch. From the attenuation
// terms the block solves for the light's range and, when the range is
// positive, sends six quad corners on out_ch, each with its buffer slot.
// A light without a positive range sends nothing.
// A light is processed alone: in_ch.ready is high only while the block is
// idle. The multiply phase runs on one shared 33x33 multiplier, the square
// root yields one result bit a cycle and the divider one quotient bit a
// cycle. A light whose quadratic product is zero skips the square root,
// and each corner is loaded into the output register and held there until
// it is taken on out_ch.
// While out_ch.ready is low the current corner holds and the block waits.
// Reset clears the slot counter and drops out_ch.valid; the slot counter
// also clears once a light marked batch_end is finished, with or without corners.
`default_nettype none
module light_range_quad_emitter #(
  parameter int BUFFER_VERTICES = 8192
) (
  input  wire        clk,
  input  wire        rst_n,
  lrqe_in_if.sink    in_ch,
  lrqe_out_if.source out_ch
);
  import lrqe_pkg::*;

  lrqe_cmd_t    cmd;
  lrqe_status_t status;

  lrqe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  lrqe_datapath #(
    .BUFFER_VERTICES (BUFFER_VERTICES)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .status (status)
  );

endmodule
`default_nettype wire

// ----- design/lrqe_ctrl.sv -----
// Sequencer of the light range quad emitter.
// Uses lrqe_pkg; drives the datapath through lrqe_cmd_t and reads lrqe_status_t.
`default_nettype none
module lrqe_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  lrqe_pkg::lrqe_status_t status,
  output lrqe_pkg::lrqe_cmd_t  cmd
);
  import lrqe_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CALC  = 8'b0000_0010,
    S_SQRT  = 8'b0000_0100,
    S_PREP  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_RANGE = 8'b0010_0000,
    S_LOAD  = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    cmd       = '0;
    cmd.step  = cnt_r[3:0];
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (cnt_r == CALC_LAST) begin
          cnt_nxt = '0;
          if (status.calc_skip) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else if (status.a_zero) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt  = '0;
        if (status.prep_skip) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        if (status.range_zero) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.latch_range = 1'b1;
          state_nxt       = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_vtx = 1'b1;
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        if (status.out_taken) begin
          if (status.out_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/lrqe_datapath.sv -----
// Datapath of the light range quad emitter: shared multiplier, bit-serial
// square root and divider, slot counter and vertex output register.
// Uses lrqe_pkg and the channel interfaces in lrqe_if.sv.
`default_nettype none
module lrqe_datapath #(
  parameter int BUFFER_VERTICES = 8192
) (
  input  wire                   clk,
  input  wire                   rst_n,
  lrqe_in_if.sink               in_ch,
  lrqe_out_if.source            out_ch,
  input  lrqe_pkg::lrqe_cmd_t   cmd,
  output lrqe_pkg::lrqe_status_t status
);
  import lrqe_pkg::*;

  localparam int SLOT_W = $clog2(BUFFER_VERTICES + 1);
  localparam logic [SLOT_W-1:0] SLOT_CAP  = SLOT_W'(BUFFER_VERTICES);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUFFER_VERTICES - 1);

  logic signed [31:0] px_r, py_r, cr_r, cg_r, cb_r, kc_r, kl_r, kq_r, kb_r;
  logic               batch_end_r;
  logic signed [65:0] prod_r;
  logic signed [63:0] a_r, b_r, c_r;
  logic [63:0]        ma_r, mb_r, mc_r;
  logic [127:0]       b2_r, ac_r;
  logic [127:0]       sq_num_r, sq_res_r, sq_bit_r;
  logic [DIV_W-1:0]   dv_num_r, dv_q_r;
  logic [63:0]        dv_rem_r, dv_den_r;
  logic [RANGE_W-1:0] range_r;
  logic [2:0]         corner_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               out_valid_r, out_last_r, out_full_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [12:0]        out_slot_r;

  logic signed [32:0] mul_x, mul_y;
  logic signed [31:0] mx;
  logic [127:0]       part, ac4, delta, sq_t;
  logic               add_case, quad_skip, lin_skip;
  logic [63:0]        root;
  logic [64:0]        nmag;
  logic               n_neg;
  logic [64:0]        dv_trial;
  logic [RANGE_W-1:0] range_cap;
  logic signed [41:0] vx, vy;
  logic [SLOT_W-1:0]  slot_use;
  logic [SLOT_W+12:0] slot_ext;

  function automatic logic signed [31:0] sat42(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v[41] && !(&v[40:31])) begin
      r = 32'sh8000_0000;
    end else if (!v[41] && (|v[40:31])) begin
      r = 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (cmd.step)
      4'd0:  begin mul_x = 33'(kq_r); mul_y = 33'(kb_r); end
      4'd1:  begin mul_x = 33'(kl_r); mul_y = 33'(kb_r); end
      4'd2:  begin mul_x = 33'(kc_r); mul_y = 33'(kb_r); end
      4'd5:  begin mul_x = {1'b0, mb_r[31:0]};  mul_y = {1'b0, mb_r[31:0]};  end
      4'd6:  begin mul_x = {1'b0, mb_r[31:0]};  mul_y = {1'b0, mb_r[63:32]}; end
      4'd7:  begin mul_x = {1'b0, mb_r[63:32]}; mul_y = {1'b0, mb_r[31:0]};  end
      4'd8:  begin mul_x = {1'b0, mb_r[63:32]}; mul_y = {1'b0, mb_r[63:32]}; end
      4'd9:  begin mul_x = {1'b0, ma_r[31:0]};  mul_y = {1'b0, mc_r[31:0]};  end
      4'd10: begin mul_x = {1'b0, ma_r[31:0]};  mul_y = {1'b0, mc_r[63:32]}; end
      4'd11: begin mul_x = {1'b0, ma_r[63:32]}; mul_y = {1'b0, mc_r[31:0]};  end
      4'd12: begin mul_x = {1'b0, ma_r[63:32]}; mul_y = {1'b0, mc_r[63:32]}; end
      default: ;
    endcase
  end

  always_comb begin
    mx = cr_r;
    if (cg_r > mx) mx = cg_r;
    if (cb_r > mx) mx = cb_r;
    case (cmd.step)
      4'd7, 4'd8, 4'd11, 4'd12: part = {64'b0, prod_r[63:0]} << 32;
      4'd9, 4'd13:              part = {64'b0, prod_r[63:0]} << 64;
      default:                  part = {64'b0, prod_r[63:0]};
    endcase
  end

  always_comb begin
    ac4       = ac_r << 2;
    add_case  = (c_r != 0) && (a_r[63] != c_r[63]);
    quad_skip = !add_case && (b2_r < ac4);
    lin_skip  = (b_r == 0) || (c_r == 0) || (c_r[63] == b_r[63]);
    delta     = add_case ? (b2_r + ac4) : (b2_r - ac4);
    sq_t      = sq_res_r + sq_bit_r;
    root      = sq_res_r[63:0];
    if (b_r <= 0) begin
      nmag  = {1'b0, mb_r} + {1'b0, root};
      n_neg = 1'b0;
    end else if (root >= mb_r) begin
      nmag  = {1'b0, root - mb_r};
      n_neg = 1'b0;
    end else begin
      nmag  = {1'b0, mb_r - root};
      n_neg = 1'b1;
    end
    dv_trial = {dv_rem_r, dv_num_r[DIV_W-1]};
    if (dv_q_r > DIV_W'(64'h100_0000_0000)) begin
      range_cap = {1'b1, {(RANGE_W-1){1'b0}}};
    end else begin
      range_cap = dv_q_r[RANGE_W-1:0];
    end
    vx = corner_x_neg(corner_r) ? (42'(px_r) - 42'(range_r)) : (42'(px_r) + 42'(range_r));
    vy = corner_y_neg(corner_r) ? (42'(py_r) - 42'(range_r)) : (42'(py_r) + 42'(range_r));
    slot_use = (slot_r < SLOT_CAP) ? slot_r : SLOT_LAST;
    slot_ext = {13'b0, slot_use};
  end

  always_comb begin
    status.a_zero     = (a_r == 0);
    status.calc_skip  = (a_r == 0) ? lin_skip : quad_skip;
    status.prep_skip  = (nmag == 0) || (n_neg != a_r[63]);
    status.range_zero = (dv_q_r == 0);
    status.out_taken  = out_valid_r && out_ch.ready;
    status.out_last   = out_last_r;
  end

  assign in_ch.ready        = cmd.load;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.vertex_x    = out_x_r;
  assign out_ch.vertex_y    = out_y_r;
  assign out_ch.vertex_slot = out_slot_r;
  assign out_ch.last_vertex = out_last_r;
  assign out_ch.buffer_full = out_full_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= in_ch.light_x;         py_r <= in_ch.light_y;
      cr_r <= in_ch.color_red;       cg_r <= in_ch.color_green;
      cb_r <= in_ch.color_blue;      kc_r <= in_ch.atten_constant;
      kl_r <= in_ch.atten_linear;    kq_r <= in_ch.atten_quadratic;
      kb_r <= in_ch.atten_bias;      batch_end_r <= in_ch.batch_end;
    end
    if (cmd.calc) begin
      prod_r <= mul_x * mul_y;
      case (cmd.step)
        4'd1: a_r <= prod_r[63:0];
        4'd2: b_r <= prod_r[63:0];
        4'd3: c_r <= prod_r[63:0] - (64'(mx) <<< 16);
        4'd4: begin
          ma_r <= mag(a_r);
          mb_r <= mag(b_r);
          mc_r <= mag(c_r);
          b2_r <= '0;
          ac_r <= '0;
        end
        4'd6, 4'd7, 4'd8, 4'd9:     b2_r <= b2_r + part;
        4'd10, 4'd11, 4'd12, 4'd13: ac_r <= ac_r + part;
        4'd14: begin
          sq_num_r <= delta;
          sq_res_r <= '0;
          sq_bit_r <= 128'd1 << 126;
          dv_num_r <= DIV_W'({mc_r, 16'b0});
          dv_den_r <= mb_r;
          dv_rem_r <= '0;
          dv_q_r   <= '0;
        end
        default: ;
      endcase
    end
    if (cmd.sqrt_step) begin
      if (sq_num_r >= sq_t) begin
        sq_num_r <= sq_num_r - sq_t;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.prep) begin
      dv_num_r <= DIV_W'({nmag, 16'b0});
      dv_den_r <= {ma_r[62:0], 1'b0};
      dv_rem_r <= '0;
      dv_q_r   <= '0;
    end
    if (cmd.div_step) begin
      dv_num_r <= dv_num_r << 1;
      if (dv_trial >= {1'b0, dv_den_r}) begin
        dv_rem_r <= 64'(dv_trial - {1'b0, dv_den_r});
        dv_q_r   <= {dv_q_r[DIV_W-2:0], 1'b1};
      end else begin
        dv_rem_r <= dv_trial[63:0];
        dv_q_r   <= {dv_q_r[DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.latch_range) begin
      range_r <= range_cap;
    end
    if (cmd.load_vtx) begin
      out_x_r    <= sat42(vx);
      out_y_r    <= sat42(vy);
      out_slot_r <= slot_ext[SLOT_OUT_W-1:0];
      out_full_r <= (slot_r >= SLOT_CAP);
      out_last_r <= (corner_r == LAST_CORNER);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      corner_r    <= '0;
    end else begin
      if (cmd.load_vtx) begin
        out_valid_r <= 1'b1;
        corner_r    <= corner_r + 3'd1;
        if (slot_r < SLOT_CAP) begin
          slot_r <= slot_r + 1'b1;
        end
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.latch_range) begin
        corner_r <= '0;
      end
      if (cmd.finish && batch_end_r) begin
        slot_r <= '0;
      end
    end
  end

endmodule
`default_nettype wire
